// File: hdl/assert_macros.svh
// Assertion macros used by the engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, cond, prop)
`define ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif
`endif

// File: hdl/mbdc_pkg.sv
// Types and constants of the mipmap downsample chain.
package mbdc_pkg;

    localparam int unsigned CfgDimW = 11;
    localparam int unsigned ChanW   = 8;
    localparam int unsigned LevelW  = 4;
    localparam int unsigned CoordW  = 9;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic               restart;
        logic [CfgDimW-1:0] width;
        logic [CfgDimW-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [ChanW-1:0]  alpha;
        logic [ChanW-1:0]  blue;
        logic [ChanW-1:0]  green;
        logic [ChanW-1:0]  red;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] x;
        logic [LevelW-1:0] level;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_WAIT,
        ST_EMIT,
        ST_FLUSH
    } seq_state_t;

endpackage

// File: hdl/mbdc_engine.sv
// Level sequencer with the pair-sum line memory and result output register.
`include "assert_macros.svh"
module mbdc_engine #(
    parameter int unsigned MAX_DIM    = 1024,
    parameter int unsigned MAX_LEVELS = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbdc_pkg::cfg_t      cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mbdc_pkg::result_t   m_result,
    output logic                m_tlast
);
    import mbdc_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIM);
    localparam int unsigned DIM_W = CNT_W + 1;
    localparam int unsigned LVL_W = $clog2(MAX_LEVELS);

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0] col_cnt_reg [MAX_LEVELS];
    logic [CNT_W-1:0] row_cnt_reg [MAX_LEVELS];
    logic [31:0]      hold_reg    [MAX_LEVELS-1];
    logic [35:0]      line_mem    [MAX_DIM];
    logic [35:0]      line_rd_reg;
    logic             line_oob_reg;

    logic [LVL_W-1:0] s_reg;
    logic [DIM_W-1:0] ws_reg, hs_reg;
    logic [CNT_W-1:0] off_reg;
    logic [CNT_W-1:0] x_reg, y_reg;
    logic [3:0][7:0]  pix_reg;
    logic [3:0][8:0]  hsum_reg;
    logic [3:0][9:0]  tot_reg;
    result_t          pend_reg;
    logic             pend_valid_reg;
    result_t          out_reg;
    logic             out_valid_reg, out_last_reg;

    logic [CNT_W-1:0] x, y;
    logic [DIM_W-1:0] wd, hd, ws_c, hs_c;
    logic [CNT_W:0]   idx;
    logic [3:0][8:0]  hsum;
    logic             top_lvl, trimmed, x_wrap, y_wrap;
    logic             step_read, step_direct, hold_wr, line_wr;
    logic             slot_free, emit_fire;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CfgDimW-1:0] v);
        logic [DIM_W+CfgDimW-1:0] w;
        w = (DIM_W+CfgDimW)'(v);
        if (v == '0) return DIM_W'(1);
        if (w > (DIM_W+CfgDimW)'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return w[DIM_W-1:0];
    endfunction

    assign ws_c = clamp_dim(cfg.width);
    assign hs_c = clamp_dim(cfg.height);

    // Level evaluation for the level under the sequencer.
    always_comb begin
        x       = col_cnt_reg[s_reg];
        y       = row_cnt_reg[s_reg];
        wd      = ((ws_reg >> 1) == '0) ? DIM_W'(1) : (ws_reg >> 1);
        hd      = ((hs_reg >> 1) == '0) ? DIM_W'(1) : (hs_reg >> 1);
        top_lvl = (ws_reg == DIM_W'(1) && hs_reg == DIM_W'(1))
                  || s_reg == LVL_W'(MAX_LEVELS - 1);
        x_wrap  = (DIM_W'(x) + DIM_W'(1)) >= ws_reg;
        y_wrap  = (DIM_W'(y) + DIM_W'(1)) >= hs_reg;
        trimmed = (ws_reg > DIM_W'(1) && DIM_W'(x) >= {wd[DIM_W-2:0], 1'b0})
                  || (hs_reg > DIM_W'(1) && DIM_W'(y) >= {hd[DIM_W-2:0], 1'b0});
        idx     = (CNT_W+1)'(off_reg) + (CNT_W+1)'(x >> 1);
        for (int c = 0; c < 4; c++) begin
            if (ws_reg == DIM_W'(1)) begin
                hsum[c] = {pix_reg[c], 1'b0};
            end else begin
                hsum[c] = 9'(hold_reg[s_reg[LVL_W-1:0]][8*c +: 8]) + 9'(pix_reg[c]);
            end
        end
        hold_wr     = 1'b0;
        line_wr     = 1'b0;
        step_read   = 1'b0;
        step_direct = 1'b0;
        if (top_lvl || trimmed) begin
            step_read = 1'b0;
        end else if (ws_reg != DIM_W'(1) && !x[0]) begin
            hold_wr   = 1'b1;
        end else if (hs_reg == DIM_W'(1)) begin
            step_direct = 1'b1;
        end else if (!y[0]) begin
            line_wr   = idx < (CNT_W+1)'(MAX_DIM);
        end else begin
            step_read = 1'b1;
        end
    end

    assign slot_free = !out_valid_reg || m_tready;
    assign emit_fire = !pend_valid_reg || slot_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_STEP;
            ST_STEP: begin
                priority if (step_read) state_next = ST_WAIT;
                else if (step_direct) state_next = ST_EMIT;
                else if (pend_valid_reg) state_next = ST_FLUSH;
                else state_next = ST_IDLE;
            end
            ST_WAIT:  state_next = ST_EMIT;
            ST_EMIT:  if (emit_fire) state_next = ST_STEP;
            ST_FLUSH: if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                col_cnt_reg[l] <= '0;
                row_cnt_reg[l] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg.restart) begin
                for (int l = 0; l < MAX_LEVELS; l++) begin
                    col_cnt_reg[l] <= '0;
                    row_cnt_reg[l] <= '0;
                end
            end else if (state_reg == ST_STEP && !top_lvl) begin
                col_cnt_reg[s_reg] <= x_wrap ? '0 : x + CNT_W'(1);
                if (x_wrap) row_cnt_reg[s_reg] <= y_wrap ? '0 : y + CNT_W'(1);
            end
            if (state_reg == ST_EMIT && emit_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (state_reg == ST_FLUSH && slot_free) begin
                pend_valid_reg <= 1'b0;
            end
            if (state_reg == ST_EMIT && emit_fire && pend_valid_reg) begin
                out_valid_reg <= 1'b1;
                out_reg       <= pend_reg;
                out_last_reg  <= 1'b0;
            end else if (state_reg == ST_FLUSH && slot_free) begin
                out_valid_reg <= 1'b1;
                out_reg       <= pend_reg;
                out_last_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            pix_reg <= s_tdata;
            s_reg   <= '0;
            ws_reg  <= ws_c;
            hs_reg  <= hs_c;
            off_reg <= '0;
        end
        if (state_reg == ST_STEP) begin
            x_reg    <= x;
            y_reg    <= y;
            hsum_reg <= hsum;
            for (int c = 0; c < 4; c++) tot_reg[c] <= {hsum[c], 1'b0};
            if (hold_wr) hold_reg[s_reg] <= pix_reg;
        end
        if (state_reg == ST_WAIT) begin
            for (int c = 0; c < 4; c++) begin
                tot_reg[c] <= (line_oob_reg ? 10'd0 : 10'(line_rd_reg[9*c +: 9]))
                              + 10'(hsum_reg[c]);
            end
        end
        if (state_reg == ST_EMIT && emit_fire) begin
            pend_reg.level <= LevelW'(s_reg) + LevelW'(1);
            pend_reg.x     <= CoordW'(x_reg >> 1);
            pend_reg.y     <= CoordW'(y_reg >> 1);
            pend_reg.red   <= tot_reg[0][9:2];
            pend_reg.green <= tot_reg[1][9:2];
            pend_reg.blue  <= tot_reg[2][9:2];
            pend_reg.alpha <= tot_reg[3][9:2];
            for (int c = 0; c < 4; c++) pix_reg[c] <= tot_reg[c][9:2];
            s_reg   <= s_reg + LVL_W'(1);
            ws_reg  <= ((ws_reg >> 1) == '0) ? DIM_W'(1) : (ws_reg >> 1);
            hs_reg  <= ((hs_reg >> 1) == '0) ? DIM_W'(1) : (hs_reg >> 1);
            off_reg <= off_reg + CNT_W'(((ws_reg >> 1) == '0) ? DIM_W'(1) : (ws_reg >> 1));
        end
    end

    // Line memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_STEP && line_wr) begin
            line_mem[idx[CNT_W-1:0]] <= {hsum[3], hsum[2], hsum[1], hsum[0]};
        end
        if (state_reg == ST_STEP && step_read) begin
            line_rd_reg  <= line_mem[idx[CNT_W-1:0]];
            line_oob_reg <= idx >= (CNT_W+1)'(MAX_DIM);
        end
    end

    `ASSERT_IMPLIES(a_idle_no_pend, aclk, aresetn, s_tready, !pend_valid_reg)
    `ASSERT_IMPLIES(a_wait_after_step, aclk, aresetn, state_reg == ST_WAIT, $past(state_reg) == ST_STEP)
    `ASSERT_NEXT(a_flush_marks_last, aclk, aresetn, state_reg == ST_FLUSH && slot_free, m_tvalid && m_tlast)
    `ASSERT_IMPLIES(a_level_bound, aclk, aresetn, state_reg != ST_IDLE, s_reg < LVL_W'(MAX_LEVELS))
endmodule

// File: hdl/mipmap_box_downsample_chain_top.sv
// Top level: configuration registers and the streaming mipmap engine.
//  channel | direction | content
//  s_      | in        | base RGBA8 pixels, raster order
//  m_      | out       | mip pixels with level, position and burst end
//  apb     | in/out    | image_width at 0x0, image_height at 0x4
// An input that ends at the base level returns the sequencer to idle. Each mip
// pixel it completes passes through the step and emit states, and the wait state too
// when an odd-row level waits on the line memory read; a burst's last result leaves via flush.
// Reset is synchronous and active low and clears counters and handshakes.
// A stalled result channel holds the sequencer once its pending result cannot move.
module mipmap_box_downsample_chain_top #(
    parameter int unsigned MAX_DIM    = 1024,
    parameter int unsigned MAX_LEVELS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // mip_level, pixel_x, pixel_y, red/green/blue/alpha_avg
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbdc_pkg::*;

    logic [CfgDimW-1:0] width_reg, height_reg;
    logic               restart_reg;
    logic               wr_req;
    cfg_t               cfg;
    result_t            res;

    assign pready = 1'b1;
    assign wr_req = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= CfgDimW'(1024);
            height_reg  <= CfgDimW'(1024);
            restart_reg <= 1'b0;
        end else begin
            restart_reg <= wr_req;
            if (wr_req) begin
                unique case (paddr[2])
                    REG_WIDTH:  width_reg  <= pwdata[CfgDimW-1:0];
                    REG_HEIGHT: height_reg <= pwdata[CfgDimW-1:0];
                    default:    width_reg  <= width_reg;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.restart = restart_reg;
    assign cfg.width   = width_reg;
    assign cfg.height  = height_reg;

    mbdc_engine #(
        .MAX_DIM    (MAX_DIM),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (res),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = {2'b00, res};
endmodule
